@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, off while reset is high.
`define MBET_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mandelbrot pixel check failed");

// Implication into the next cycle, off while reset is high.
`define MBET_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mandelbrot pixel check failed");

// Implication into the next cycle that also holds through reset.
`define MBET_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mandelbrot pixel check failed");

`endif

@@ rtl/mbet_pkg.sv @@
// Shared types, constants and helper functions of the Mandelbrot pixel unit.
// Depends on nothing; every file of the block but assert_macros.svh imports it.
`default_nettype none

package mbet_pkg;

  localparam int COORD_W   = 10;
  localparam int FIX_W     = 32;
  localparam int ITER_W    = 16;
  localparam int COLOUR_W  = 24;
  localparam int FRAC_BITS = 28;
  localparam int CFG_IDX_W = 3;
  localparam int WIDE_W    = 66;

  localparam logic [COLOUR_W-1:0] COLOUR_GREEN = 24'h00FF00;
  localparam logic [COLOUR_W-1:0] COLOUR_RED   = 24'hFF0000;
  localparam logic [COLOUR_W-1:0] COLOUR_BLACK = 24'h000000;

  localparam logic [ITER_W-1:0] GREEN_BELOW = 16'd8;
  localparam logic [ITER_W-1:0] RED_BELOW   = 16'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_EDGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_EDGE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 3'd4;

  localparam logic signed [FIX_W-1:0] RST_LEFT_EDGE = 32'shE000_0000;
  localparam logic signed [FIX_W-1:0] RST_TOP_EDGE  = 32'sh1200_0000;
  localparam logic signed [FIX_W-1:0] RST_STEP_X    = 32'sh0013_3333;
  localparam logic signed [FIX_W-1:0] RST_STEP_Y    = 32'shFFEC_CCCD;
  localparam logic [ITER_W-1:0]       RST_MAX_ITER  = 16'd500;

  localparam logic signed [WIDE_W-1:0] FIX_MAX_WIDE = 66'sd2147483647;
  localparam logic signed [WIDE_W-1:0] FIX_MIN_WIDE = -66'sd2147483648;

  typedef logic signed [FIX_W-1:0] fix_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    fix_t               cr;
    fix_t               ci;
  } point_t;

  typedef struct packed {
    fix_t              left_edge;
    fix_t              top_edge;
    fix_t              step_x;
    fix_t              step_y;
    logic [ITER_W-1:0] max_iter;
  } cfg_t;

  // Clamp a wide signed value into the 32-bit fixed-point range.
  function automatic fix_t sat_fix(input logic signed [WIDE_W-1:0] v);
    fix_t r;
    if (v > FIX_MAX_WIDE) begin
      r = fix_t'(FIX_MAX_WIDE);
    end else if (v < FIX_MIN_WIDE) begin
      r = fix_t'(FIX_MIN_WIDE);
    end else begin
      r = fix_t'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mbet_queue.sv @@
// Small FIFO of mapped points between the front and the iteration engine.
// Depends on mbet_pkg for the point type.
`default_nettype none

module mbet_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire mbet_pkg::point_t push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output mbet_pkg::point_t     pop_data
);
  import mbet_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  point_t            entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != FULL_CNT);
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/mbet_front.sv @@
// Front of the pixel unit: accepts pixel words and maps them to points c.
// Depends on mbet_pkg for the configuration and point types.
`default_nettype none

module mbet_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire mbet_pkg::cfg_t              cfg,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [mbet_pkg::COORD_W-1:0] pixel_x,
  input  wire logic [mbet_pkg::COORD_W-1:0] pixel_y,
  output logic                             push_valid,
  input  wire logic                        push_ready,
  output mbet_pkg::point_t                 push_data
);
  import mbet_pkg::*;

  localparam int PROD_W = COORD_W + 1 + FIX_W;

  logic               s1_valid;
  logic [COORD_W-1:0] s1_x;
  logic [COORD_W-1:0] s1_y;
  logic               s2_valid;
  logic [COORD_W-1:0] s2_x;
  logic [COORD_W-1:0] s2_y;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic               s2_move;
  logic               s1_move;

  assign s2_move  = s2_valid && push_ready;
  assign s1_move  = s1_valid && (!s2_valid || s2_move);
  assign in_ready = !s1_valid || s1_move;

  // The offset add and clamp happen on the registered products.
  assign push_valid   = s2_valid;
  assign push_data.x  = s2_x;
  assign push_data.y  = s2_y;
  assign push_data.cr = sat_fix(WIDE_W'(cfg.left_edge) + WIDE_W'(prod_x));
  assign push_data.ci = sat_fix(WIDE_W'(cfg.top_edge) + WIDE_W'(prod_y));

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_x <= pixel_x;
      s1_y <= pixel_y;
    end
    if (s1_move) begin
      s2_x   <= s1_x;
      s2_y   <= s1_y;
      prod_x <= $signed({1'b0, s1_x}) * cfg.step_x;
      prod_y <= $signed({1'b0, s1_y}) * cfg.step_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/mbet_back.sv @@
// Iteration engine: runs z = z*z + c for one point and holds the result word.
// Depends on mbet_pkg for the configuration, point type and clamp function.
`default_nettype none

module mbet_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire mbet_pkg::cfg_t               cfg,
  input  wire logic                         pop_valid,
  output logic                              pop_ready,
  input  wire mbet_pkg::point_t             pop_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [mbet_pkg::COORD_W-1:0]      out_x,
  output logic [mbet_pkg::COORD_W-1:0]      out_y,
  output logic [mbet_pkg::ITER_W-1:0]       iter_count,
  output logic [mbet_pkg::COLOUR_W-1:0]     colour
);
  import mbet_pkg::*;

  localparam int PROD_W = 2 * FIX_W;
  localparam logic [PROD_W:0] ESC_LIMIT = (PROD_W + 1)'(4) << (2 * FRAC_BITS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  state_t             state;
  fix_t               zr;
  fix_t               zi;
  fix_t               cr;
  fix_t               ci;
  logic [COORD_W-1:0] px;
  logic [COORD_W-1:0] py;
  logic [ITER_W-1:0]  count;
  logic signed [PROD_W-1:0] rr;
  logic signed [PROD_W-1:0] ii;
  logic signed [PROD_W-1:0] ri;

  logic               escaped;
  logic               at_limit;
  logic signed [PROD_W-1:0] diff;
  logic signed [PROD_W:0]   twice_ri;
  fix_t               zr_next;
  fix_t               zi_next;
  logic               out_free;

  function automatic logic [COLOUR_W-1:0] pick_colour(input logic [ITER_W-1:0] n,
                                                      input logic [ITER_W-1:0] lim);
    logic [COLOUR_W-1:0] c;
    if (n == lim) begin
      c = COLOUR_BLACK;
    end else if (n < GREEN_BELOW) begin
      c = COLOUR_GREEN;
    end else if (n < RED_BELOW) begin
      c = COLOUR_RED;
    end else begin
      c = COLOUR_BLACK;
    end
    return c;
  endfunction

  // Both squares are non-negative, so the magnitude sum is taken unsigned.
  assign escaped  = ({1'b0, rr} + {1'b0, ii}) >= ESC_LIMIT;
  assign at_limit = (count == cfg.max_iter);
  assign diff     = rr - ii;
  assign twice_ri = $signed({ri, 1'b0});
  assign zr_next  = sat_fix(WIDE_W'(diff >>> FRAC_BITS) + WIDE_W'(cr));
  assign zi_next  = sat_fix(WIDE_W'(twice_ri >>> FRAC_BITS) + WIDE_W'(ci));
  assign out_free = !out_valid || out_ready;
  assign pop_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (pop_valid) begin
          px    <= pop_data.x;
          py    <= pop_data.y;
          cr    <= pop_data.cr;
          ci    <= pop_data.ci;
          zr    <= '0;
          zi    <= '0;
          count <= '0;
        end
      end
      ST_MUL: begin
        rr <= zr * zr;
        ii <= zi * zi;
        ri <= zr * zi;
      end
      ST_EVAL: begin
        if (!at_limit && !escaped) begin
          zr    <= zr_next;
          zi    <= zi_next;
          count <= count + ITER_W'(1);
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_x      <= px;
          out_y      <= py;
          iter_count <= count;
          colour     <= pick_colour(count, cfg.max_iter);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_HOLD && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          state <= (at_limit || escaped) ? ST_HOLD : ST_MUL;
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/mandelbrot_escape_time_pixel_top.sv @@
// Mandelbrot escape-time pixel unit: top level with the configuration registers.
// Depends on mbet_pkg, mbet_front, mbet_queue and mbet_back.
//
// Usage:
//   Each input word (pixel_x, pixel_y) names one pixel. The unit maps it to
//   c = (left_edge + x*step_x, top_edge + y*step_y) in signed Q4.28 and counts
//   the iterations of z = z*z + c until |z|^2 reaches 4 or max_iter is hit.
//   Each input word gives exactly one output word (out_x, out_y, iter_count,
//   colour), in input order. Both channels use valid/ready.
//   Registers are written through cfg_write/cfg_index/cfg_data; the user
//   must write them only while idle, as the block does not enforce it.
//   Each iteration takes a multiply state (ST_MUL) and an update state
//   (ST_EVAL), and that loop sets the throughput: the engine takes a new
//   point from the queue only after the previous result has left ST_HOLD.
//   The front keeps accepting pixels into a short queue while the engine
//   works or while a finished word waits at the output; when the receiver
//   stalls, the output word holds and the queue fills, then in_ready drops.
//   Reset (synchronous, active high) empties the queue and the pipeline,
//   drops both valids and restores the register defaults.
`default_nettype none

module mandelbrot_escape_time_pixel_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [mbet_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mbet_pkg::FIX_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [mbet_pkg::COORD_W-1:0]   pixel_x,
  input  wire logic [mbet_pkg::COORD_W-1:0]   pixel_y,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [mbet_pkg::COORD_W-1:0]        out_x,
  output logic [mbet_pkg::COORD_W-1:0]        out_y,
  output logic [mbet_pkg::ITER_W-1:0]         iter_count,
  output logic [mbet_pkg::COLOUR_W-1:0]       colour
);
  import mbet_pkg::*;

  cfg_t   cfg;
  logic   push_valid;
  logic   push_ready;
  point_t push_data;
  logic   pop_valid;
  logic   pop_ready;
  point_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_edge <= RST_LEFT_EDGE;
      cfg.top_edge  <= RST_TOP_EDGE;
      cfg.step_x    <= RST_STEP_X;
      cfg.step_y    <= RST_STEP_Y;
      cfg.max_iter  <= RST_MAX_ITER;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LEFT_EDGE: cfg.left_edge <= $signed(cfg_data);
        CFG_TOP_EDGE:  cfg.top_edge  <= $signed(cfg_data);
        CFG_STEP_X:    cfg.step_x    <= $signed(cfg_data);
        CFG_STEP_Y:    cfg.step_y    <= $signed(cfg_data);
        CFG_MAX_ITER:  cfg.max_iter  <= cfg_data[ITER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mbet_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  mbet_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mbet_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_x),
    .out_y      (out_y),
    .iter_count (iter_count),
    .colour     (colour)
  );

endmodule

`default_nettype wire

@@ rtl/mbet_checker.sv @@
// Port-level checks of the Mandelbrot pixel unit, bound to its top level.
// Depends on mbet_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mbet_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [mbet_pkg::COORD_W-1:0]   out_x,
  input wire logic [mbet_pkg::COORD_W-1:0]   out_y,
  input wire logic [mbet_pkg::ITER_W-1:0]    iter_count,
  input wire logic [mbet_pkg::COLOUR_W-1:0]  colour
);
  import mbet_pkg::*;

  logic [2*COORD_W+ITER_W+COLOUR_W-1:0] out_word;
  logic                                 late_count;
  logic                                 red_count;

  assign out_word   = {out_x, out_y, iter_count, colour};
  assign late_count = (iter_count >= RED_BELOW);
  assign red_count  = (iter_count >= GREEN_BELOW) && (iter_count < RED_BELOW);

  // A stalled result word keeps its contents.
  `MBET_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_word))

  // Reset leaves no result word pending.
  `MBET_ASSERT_NEXT_ALWAYS(a_reset_clears, clk, rst, !out_valid)

  // Counts of sixteen and up (slow escapes, and points in the set when max_iter is that high) are always black.
  `MBET_ASSERT_NOW(a_black_late, clk, rst, out_valid && late_count, colour == COLOUR_BLACK)

  // Red only marks counts from eight to fifteen.
  `MBET_ASSERT_NOW(a_red_band, clk, rst, out_valid && colour == COLOUR_RED, red_count)

endmodule

bind mandelbrot_escape_time_pixel_top mbet_checker u_mbet_checker (.*);

`default_nettype wire
